/* rtl/arm64_instruction_encoder_assert.svh */
// assertion macros for the instruction encoder
// clocked on clk, disabled while rst_n is low
`ifndef ARM64_INSTRUCTION_ENCODER_ASSERT_SVH
`define ARM64_INSTRUCTION_ENCODER_ASSERT_SVH

// condition holds on every enabled edge
`define A64ENC_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define A64ENC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/a64enc_pkg.sv */
`timescale 1ns / 1ps
package a64enc_pkg;

  localparam int unsigned NumForms = 55;

  typedef logic [4:0] kind_t;

  localparam kind_t K_R3    = 5'd0;
  localparam kind_t K_ADDI  = 5'd1;
  localparam kind_t K_CMPI  = 5'd2;
  localparam kind_t K_LOGI  = 5'd3;
  localparam kind_t K_SHR32 = 5'd4;
  localparam kind_t K_SHR64 = 5'd5;
  localparam kind_t K_SHL32 = 5'd6;
  localparam kind_t K_SHL64 = 5'd7;
  localparam kind_t K_BR    = 5'd8;
  localparam kind_t K_BCC   = 5'd9;
  localparam kind_t K_RN    = 5'd10;
  localparam kind_t K_CMPR  = 5'd11;
  localparam kind_t K_CSET  = 5'd12;
  localparam kind_t K_PAIR  = 5'd13;
  localparam kind_t K_LS4   = 5'd14;
  localparam kind_t K_LS8   = 5'd15;
  localparam kind_t K_RZM   = 5'd16;
  localparam kind_t K_R2    = 5'd17;
  localparam kind_t K_MW2   = 5'd18;
  localparam kind_t K_MW4   = 5'd19;
  localparam kind_t K_MSUB  = 5'd20;
  localparam kind_t K_MULL  = 5'd21;
  localparam kind_t K_BAD   = 5'd22;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_MISALIGN = 2'd1;
  localparam status_t ST_RANGE    = 2'd2;
  localparam status_t ST_BAD_FORM = 2'd3;

  localparam logic [4:0] REG_ZR = 5'd31;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 40;

  typedef struct packed {
    logic [5:0]         mode;
    logic [4:0]         reg_d;
    logic [4:0]         reg_n;
    logic [4:0]         reg_m;
    logic [4:0]         reg_a;
    logic [15:0]        imm_value;
    logic [5:0]         rot_or_shift;
    logic [5:0]         mask_width;
    logic [1:0]         half_sel;
    logic [3:0]         cond;
    logic signed [27:0] byte_offset;
  } req_t;

  typedef struct packed {
    logic [31:0] word;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic [31:0] base;
    kind_t       kind;
  } form_t;

  function automatic form_t form_lookup(input logic [5:0] mode);
    form_t f;
    case (mode)
      6'd0:  f = '{32'h0B000000, K_R3};
      6'd1:  f = '{32'h8B000000, K_R3};
      6'd2:  f = '{32'h11000000, K_ADDI};
      6'd3:  f = '{32'h91000000, K_ADDI};
      6'd4:  f = '{32'h0A000000, K_R3};
      6'd5:  f = '{32'h12000000, K_LOGI};
      6'd6:  f = '{32'h13000000, K_SHR32};
      6'd7:  f = '{32'h93400000, K_SHR64};
      6'd8:  f = '{32'h1AC02800, K_R3};
      6'd9:  f = '{32'h9AC02800, K_R3};
      6'd10: f = '{32'h14000000, K_BR};
      6'd11: f = '{32'h94000000, K_BR};
      6'd12: f = '{32'h54000000, K_BCC};
      6'd13: f = '{32'hD63F0000, K_RN};
      6'd14: f = '{32'h31000000, K_CMPI};
      6'd15: f = '{32'hB1000000, K_CMPI};
      6'd16: f = '{32'h6B000000, K_CMPR};
      6'd17: f = '{32'hEB000000, K_CMPR};
      6'd18: f = '{32'h71000000, K_CMPI};
      6'd19: f = '{32'hF1000000, K_CMPI};
      6'd20: f = '{32'h1A800400, K_CSET};
      6'd21: f = '{32'h4A000000, K_R3};
      6'd22: f = '{32'hA8C00000, K_PAIR};
      6'd23: f = '{32'hB9400000, K_LS4};
      6'd24: f = '{32'hF9400000, K_LS8};
      6'd25: f = '{32'h53000000, K_SHL32};
      6'd26: f = '{32'hD3400000, K_SHL64};
      6'd27: f = '{32'h1AC02000, K_R3};
      6'd28: f = '{32'h9AC02000, K_R3};
      6'd29: f = '{32'h53000000, K_SHR32};
      6'd30: f = '{32'hD3400000, K_SHR64};
      6'd31: f = '{32'h1AC02400, K_R3};
      6'd32: f = '{32'h9AC02400, K_R3};
      6'd33: f = '{32'h2A0003E0, K_RZM};
      6'd34: f = '{32'hAA0003E0, K_RZM};
      6'd35: f = '{32'h91000000, K_R2};
      6'd36: f = '{32'h12800000, K_MW2};
      6'd37: f = '{32'h72800000, K_MW2};
      6'd38: f = '{32'hF2800000, K_MW4};
      6'd39: f = '{32'h52800000, K_MW2};
      6'd40: f = '{32'hD2800000, K_MW4};
      6'd41: f = '{32'h1B008000, K_MSUB};
      6'd42: f = '{32'h2A200000, K_RZM};
      6'd43: f = '{32'h2A000000, K_R3};
      6'd44: f = '{32'hD65F0000, K_RN};
      6'd45: f = '{32'h1AC00C00, K_R3};
      6'd46: f = '{32'h9B200000, K_MULL};
      6'd47: f = '{32'hB9000000, K_LS4};
      6'd48: f = '{32'hF9000000, K_LS8};
      6'd49: f = '{32'hA9800000, K_PAIR};
      6'd50: f = '{32'h4B000000, K_R3};
      6'd51: f = '{32'h51000000, K_ADDI};
      6'd52: f = '{32'hD1000000, K_ADDI};
      6'd53: f = '{32'h1AC00800, K_R3};
      6'd54: f = '{32'h9BA00000, K_MULL};
      default: f = '{32'h00000000, K_BAD};
    endcase
    return f;
  endfunction

endpackage

/* rtl/a64enc_encode.sv */
`timescale 1ns / 1ps
module a64enc_encode (
  input  a64enc_pkg::req_t req,
  output a64enc_pkg::res_t res
);
  import a64enc_pkg::*;

  // reserved (N=0, imms) pattern of a 32-bit logical immediate
  function automatic logic logimm_reserved(input logic [5:0] imms);
    logic [5:0] inv;
    logic [2:0] len;
    logic [5:0] levels;
    inv = ~imms;
    len = 3'd0;
    for (int i = 1; i < 6; i++) begin
      if (inv[i]) begin
        len = 3'(i);
      end
    end
    levels = (6'd1 << len) - 6'd1;
    return (inv == 6'd0) || ((imms & levels) == levels);
  endfunction

  form_t       form;
  logic [27:0] raw;
  logic [31:0] fields;
  status_t     st;
  logic [4:0]  shl32_imms;
  logic [4:0]  shl32_immr;
  logic [5:0]  shl64_imms;
  logic [5:0]  shl64_immr;
  logic        bcc_fits;
  logic        pair_fits;

  assign form       = form_lookup(req.mode);
  assign raw        = req.byte_offset;
  assign shl32_imms = 5'd31 - req.rot_or_shift[4:0];
  assign shl32_immr = 5'd0 - req.rot_or_shift[4:0];
  assign shl64_imms = 6'd63 - req.rot_or_shift;
  assign shl64_immr = 6'd0 - req.rot_or_shift;
  assign bcc_fits   = (raw[27:20] == {8{raw[27]}});
  assign pair_fits  = (raw[27:9] == {19{raw[27]}});

  always_comb begin
    fields = 32'd0;
    st     = ST_OK;
    case (form.kind)
      K_R3: begin
        fields = {11'd0, req.reg_m, 6'd0, req.reg_n, req.reg_d};
      end
      K_R2: begin
        fields = {22'd0, req.reg_n, req.reg_d};
      end
      K_RZM: begin
        fields = {11'd0, req.reg_m, 6'd0, REG_ZR, req.reg_d};
      end
      K_CMPR: begin
        fields = {11'd0, req.reg_m, 6'd0, req.reg_n, REG_ZR};
      end
      K_RN: begin
        fields = {22'd0, req.reg_n, 5'd0};
      end
      K_MSUB: begin
        fields = {11'd0, req.reg_m, 1'b0, req.reg_a, req.reg_n, req.reg_d};
      end
      K_MULL: begin
        fields = {11'd0, req.reg_m, 1'b0, REG_ZR, req.reg_n, req.reg_d};
      end
      K_ADDI, K_CMPI: begin
        if (req.imm_value[15:12] != 4'd0 || req.half_sel[1]) begin
          st = ST_RANGE;
        end else begin
          fields = {9'd0, req.half_sel[0], req.imm_value[11:0], req.reg_n,
                    (form.kind == K_ADDI) ? req.reg_d : REG_ZR};
        end
      end
      K_LOGI: begin
        if (logimm_reserved(req.mask_width)) begin
          st = ST_RANGE;
        end else begin
          fields = {10'd0, req.rot_or_shift, req.mask_width, req.reg_n, req.reg_d};
        end
      end
      K_SHR32: begin
        if (req.rot_or_shift[5]) begin
          st = ST_RANGE;
        end else begin
          fields = {10'd0, req.rot_or_shift, 6'd31, req.reg_n, req.reg_d};
        end
      end
      K_SHR64: begin
        fields = {10'd0, req.rot_or_shift, 6'd63, req.reg_n, req.reg_d};
      end
      K_SHL32: begin
        if (req.rot_or_shift[5]) begin
          st = ST_RANGE;
        end else begin
          fields = {11'd0, shl32_immr, 1'b0, shl32_imms, req.reg_n, req.reg_d};
        end
      end
      K_SHL64: begin
        fields = {10'd0, shl64_immr, shl64_imms, req.reg_n, req.reg_d};
      end
      K_BR: begin
        if (raw[1:0] != 2'd0) begin
          st = ST_MISALIGN;
        end else begin
          fields = {6'd0, raw[27:2]};
        end
      end
      K_BCC: begin
        if (raw[1:0] != 2'd0) begin
          st = ST_MISALIGN;
        end else if (!bcc_fits) begin
          st = ST_RANGE;
        end else begin
          fields = {8'd0, raw[20:2], 1'b0, req.cond};
        end
      end
      K_CSET: begin
        if (req.cond[3:1] == 3'b111) begin
          st = ST_RANGE;
        end else begin
          fields = {11'd0, REG_ZR, req.cond[3:1], ~req.cond[0], 2'd0, REG_ZR,
                    req.reg_d};
        end
      end
      K_PAIR: begin
        if (raw[2:0] != 3'd0) begin
          st = ST_MISALIGN;
        end else if (!pair_fits) begin
          st = ST_RANGE;
        end else begin
          fields = {10'd0, raw[9:3], req.reg_a, req.reg_n, req.reg_d};
        end
      end
      K_LS4: begin
        if (raw[1:0] != 2'd0) begin
          st = ST_MISALIGN;
        end else if (raw[27:14] != 14'd0) begin
          st = ST_RANGE;
        end else begin
          fields = {10'd0, raw[13:2], req.reg_n, req.reg_d};
        end
      end
      K_LS8: begin
        if (raw[2:0] != 3'd0) begin
          st = ST_MISALIGN;
        end else if (raw[27:15] != 13'd0) begin
          st = ST_RANGE;
        end else begin
          fields = {10'd0, raw[14:3], req.reg_n, req.reg_d};
        end
      end
      K_MW2: begin
        if (req.half_sel[1]) begin
          st = ST_RANGE;
        end else begin
          fields = {9'd0, req.half_sel, req.imm_value, req.reg_d};
        end
      end
      K_MW4: begin
        fields = {9'd0, req.half_sel, req.imm_value, req.reg_d};
      end
      default: begin
        st = ST_BAD_FORM;
      end
    endcase
  end

  assign res.word   = (st == ST_OK) ? (form.base | fields) : 32'd0;
  assign res.status = st;

endmodule

/* rtl/arm64_instruction_encoder.sv */
`timescale 1ns / 1ps
// channel   dir  width  contents
// in_       in   88     one encode request
// out_      out  40     instruction word and status
//
// one item per cycle unless the output stalls
// the request register feeds the encoder logic, which feeds the output register
// rst_n synchronous, active low, clears both valid flags
// a stalled output holds its item; the request stage keeps accepting while it can move forward
module arm64_instruction_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // mode, reg_d, reg_n, reg_m, reg_a, imm_value, rot_or_shift, mask_width,
  // half_sel, cond, byte_offset
  input  logic [a64enc_pkg::InDataW-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // word, status, zero fill
  output logic [a64enc_pkg::OutDataW-1:0]  out_tdata
);
  import a64enc_pkg::*;

  logic in_valid_r;
  logic in_valid_nxt;
  req_t req_r;
  req_t req_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t res_r;
  res_t res_nxt;
  res_t enc_res;
  logic out_ready;

  assign out_ready = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_ready;

  always_comb begin
    req_nxt              = req_r;
    in_valid_nxt         = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      req_nxt.mode         = in_tdata[5:0];
      req_nxt.reg_d        = in_tdata[10:6];
      req_nxt.reg_n        = in_tdata[15:11];
      req_nxt.reg_m        = in_tdata[20:16];
      req_nxt.reg_a        = in_tdata[25:21];
      req_nxt.imm_value    = in_tdata[41:26];
      req_nxt.rot_or_shift = in_tdata[47:42];
      req_nxt.mask_width   = in_tdata[53:48];
      req_nxt.half_sel     = in_tdata[55:54];
      req_nxt.cond         = in_tdata[59:56];
      req_nxt.byte_offset  = in_tdata[87:60];
    end
  end

  a64enc_encode u_encode (
    .req (req_r),
    .res (enc_res)
  );

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = in_valid_r;
      if (in_valid_r) begin
        res_nxt = enc_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.status, res_r.word};

`include "arm64_instruction_encoder_assert.svh"

  `A64ENC_ASSERT_HOLDS(a_err_word_zero, !out_valid_r || res_r.status == ST_OK || res_r.word == 32'd0, "error result carries a nonzero word")
  `A64ENC_ASSERT_NEXT(a_stage_moves, in_valid_r && out_ready, out_valid_r, "request did not reach the output register")
  `A64ENC_ASSERT_HOLDS(a_stall_only_full, in_tready || (in_valid_r && out_valid_r), "input stalled with a free stage")

endmodule

/* sim/tb_arm64_instruction_encoder.sv */
`timescale 1ns / 1ps
module tb_arm64_instruction_encoder;
  import a64enc_pkg::*;

  typedef enum logic [5:0] {
    F_ADD_WR, F_ADD_XR, F_ADD_WI, F_ADD_XI, F_AND_WR, F_AND_WI, F_ASR_WI, F_ASR_XI,
    F_ASRV_W, F_ASRV_X, F_B, F_BL, F_BCOND, F_BLR, F_CMN_WI, F_CMN_XI,
    F_CMP_WR, F_CMP_XR, F_CMP_WI, F_CMP_XI, F_CSET_W, F_EOR_WR, F_LDP_XPOST, F_LDR_W,
    F_LDR_X, F_LSL_WI, F_LSL_XI, F_LSLV_W, F_LSLV_X, F_LSR_WI, F_LSR_XI, F_LSRV_W,
    F_LSRV_X, F_MOV_WR, F_MOV_XR, F_MOV_SP, F_MOVN_W, F_MOVK_W, F_MOVK_X, F_MOVZ_W,
    F_MOVZ_X, F_MSUB_W, F_MVN_W, F_ORR_WR, F_RET, F_SDIV_W, F_SMULL, F_STR_W,
    F_STR_X, F_STP_XPRE, F_SUB_WR, F_SUB_WI, F_SUB_XI, F_UDIV_W, F_UMULL
  } form_sel_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam logic [5:0] MODE_TOP = 6'h3F;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // mode, reg_d, reg_n, reg_m, reg_a, imm_value, rot_or_shift, mask_width,
  // half_sel, cond, byte_offset
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  // word, status, zero fill
  logic [OutDataW-1:0] out_tdata;

  res_t pending_encodings[$];
  int   mismatch_count = 0;
  int   quiet_cycles = 0;
  bit   sender_idle = 0;
  bit   receiver_idle = 0;
  int   hold_request = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  arm64_instruction_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t encode_request(input req_t req);
    logic [31:0] base;
    kind_t       kind;
    res_t        res;
    logic [27:0] raw;
    int          off;
    int          sa;
    int          len;
    logic [5:0]  inv;
    logic [5:0]  levels;
    logic [4:0]  dst;
    raw = req.byte_offset;
    off = {{4{raw[27]}}, raw};
    sa = int'(req.rot_or_shift);
    res.status = ST_OK;
    case (req.mode)
      F_ADD_WR:    {base, kind} = {32'h0B000000, K_R3};
      F_ADD_XR:    {base, kind} = {32'h8B000000, K_R3};
      F_ADD_WI:    {base, kind} = {32'h11000000, K_ADDI};
      F_ADD_XI:    {base, kind} = {32'h91000000, K_ADDI};
      F_AND_WR:    {base, kind} = {32'h0A000000, K_R3};
      F_AND_WI:    {base, kind} = {32'h12000000, K_LOGI};
      F_ASR_WI:    {base, kind} = {32'h13000000, K_SHR32};
      F_ASR_XI:    {base, kind} = {32'h93400000, K_SHR64};
      F_ASRV_W:    {base, kind} = {32'h1AC02800, K_R3};
      F_ASRV_X:    {base, kind} = {32'h9AC02800, K_R3};
      F_B:         {base, kind} = {32'h14000000, K_BR};
      F_BL:        {base, kind} = {32'h94000000, K_BR};
      F_BCOND:     {base, kind} = {32'h54000000, K_BCC};
      F_BLR:       {base, kind} = {32'hD63F0000, K_RN};
      F_CMN_WI:    {base, kind} = {32'h31000000, K_CMPI};
      F_CMN_XI:    {base, kind} = {32'hB1000000, K_CMPI};
      F_CMP_WR:    {base, kind} = {32'h6B000000, K_CMPR};
      F_CMP_XR:    {base, kind} = {32'hEB000000, K_CMPR};
      F_CMP_WI:    {base, kind} = {32'h71000000, K_CMPI};
      F_CMP_XI:    {base, kind} = {32'hF1000000, K_CMPI};
      F_CSET_W:    {base, kind} = {32'h1A800400, K_CSET};
      F_EOR_WR:    {base, kind} = {32'h4A000000, K_R3};
      F_LDP_XPOST: {base, kind} = {32'hA8C00000, K_PAIR};
      F_LDR_W:     {base, kind} = {32'hB9400000, K_LS4};
      F_LDR_X:     {base, kind} = {32'hF9400000, K_LS8};
      F_LSL_WI:    {base, kind} = {32'h53000000, K_SHL32};
      F_LSL_XI:    {base, kind} = {32'hD3400000, K_SHL64};
      F_LSLV_W:    {base, kind} = {32'h1AC02000, K_R3};
      F_LSLV_X:    {base, kind} = {32'h9AC02000, K_R3};
      F_LSR_WI:    {base, kind} = {32'h53000000, K_SHR32};
      F_LSR_XI:    {base, kind} = {32'hD3400000, K_SHR64};
      F_LSRV_W:    {base, kind} = {32'h1AC02400, K_R3};
      F_LSRV_X:    {base, kind} = {32'h9AC02400, K_R3};
      F_MOV_WR:    {base, kind} = {32'h2A0003E0, K_RZM};
      F_MOV_XR:    {base, kind} = {32'hAA0003E0, K_RZM};
      F_MOV_SP:    {base, kind} = {32'h91000000, K_R2};
      F_MOVN_W:    {base, kind} = {32'h12800000, K_MW2};
      F_MOVK_W:    {base, kind} = {32'h72800000, K_MW2};
      F_MOVK_X:    {base, kind} = {32'hF2800000, K_MW4};
      F_MOVZ_W:    {base, kind} = {32'h52800000, K_MW2};
      F_MOVZ_X:    {base, kind} = {32'hD2800000, K_MW4};
      F_MSUB_W:    {base, kind} = {32'h1B008000, K_MSUB};
      F_MVN_W:     {base, kind} = {32'h2A200000, K_RZM};
      F_ORR_WR:    {base, kind} = {32'h2A000000, K_R3};
      F_RET:       {base, kind} = {32'hD65F0000, K_RN};
      F_SDIV_W:    {base, kind} = {32'h1AC00C00, K_R3};
      F_SMULL:     {base, kind} = {32'h9B200000, K_MULL};
      F_STR_W:     {base, kind} = {32'hB9000000, K_LS4};
      F_STR_X:     {base, kind} = {32'hF9000000, K_LS8};
      F_STP_XPRE:  {base, kind} = {32'hA9800000, K_PAIR};
      F_SUB_WR:    {base, kind} = {32'h4B000000, K_R3};
      F_SUB_WI:    {base, kind} = {32'h51000000, K_ADDI};
      F_SUB_XI:    {base, kind} = {32'hD1000000, K_ADDI};
      F_UDIV_W:    {base, kind} = {32'h1AC00800, K_R3};
      F_UMULL:     {base, kind} = {32'h9BA00000, K_MULL};
      default:     {base, kind} = {32'h00000000, K_BAD};
    endcase
    res.word = base;
    case (kind)
      K_R3:   res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(req.reg_m) << 16);
      K_R2:   res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5);
      K_RZM:  res.word |= 32'(req.reg_d) | (32'(REG_ZR) << 5) | (32'(req.reg_m) << 16);
      K_CMPR: res.word |= 32'(REG_ZR) | (32'(req.reg_n) << 5) | (32'(req.reg_m) << 16);
      K_RN:   res.word |= 32'(req.reg_n) << 5;
      K_MSUB: res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(req.reg_a) << 10)
                        | (32'(req.reg_m) << 16);
      K_MULL: res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(REG_ZR) << 10)
                        | (32'(req.reg_m) << 16);
      K_ADDI, K_CMPI: begin
        dst = (kind == K_ADDI) ? req.reg_d : REG_ZR;
        if (req.imm_value >= 16'h1000 || req.half_sel > 2'd1) res.status = ST_RANGE;
        else res.word |= 32'(dst) | (32'(req.reg_n) << 5) | (32'(req.imm_value) << 10)
                       | (32'(req.half_sel) << 22);
      end
      K_LOGI: begin
        // element size follows the highest zero bit of imms
        inv = ~req.mask_width;
        len = 0;
        for (int i = 0; i < 6; i++) if (inv[i]) len = i;
        levels = (6'd1 << len) - 6'd1;
        if (inv == 6'd0 || (req.mask_width & levels) == levels) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5)
                       | (32'(req.mask_width) << 10) | (32'(req.rot_or_shift) << 16);
      end
      K_SHR32: begin
        if (sa > 31) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'd31 << 10)
                       | (32'(sa) << 16);
      end
      K_SHR64: res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'd63 << 10)
                         | (32'(sa) << 16);
      K_SHL32: begin
        if (sa > 31) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(31 - sa) << 10)
                       | (32'((32 - sa) & 31) << 16);
      end
      K_SHL64: res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(63 - sa) << 10)
                         | (32'((64 - sa) & 63) << 16);
      K_BR: begin
        if (raw[1:0] != 2'd0) res.status = ST_MISALIGN;
        else res.word |= 32'(raw[27:2]);
      end
      K_BCC: begin
        if (raw[1:0] != 2'd0) res.status = ST_MISALIGN;
        else if (off < -(1 << 20) || off > (1 << 20) - 4) res.status = ST_RANGE;
        else res.word |= (32'(raw[20:2]) << 5) | 32'(req.cond);
      end
      K_CSET: begin
        if (req.cond >= 4'd14) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(REG_ZR) << 5) | (32'(req.cond ^ 4'd1) << 12)
                       | (32'(REG_ZR) << 16);
      end
      K_PAIR: begin
        if (raw[2:0] != 3'd0) res.status = ST_MISALIGN;
        else if (off < -512 || off > 504) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(req.reg_a) << 10)
                       | (32'(raw[9:3]) << 15);
      end
      K_LS4: begin
        if (raw[1:0] != 2'd0) res.status = ST_MISALIGN;
        else if (off < 0 || off >= 'h4000) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(raw[13:2]) << 10);
      end
      K_LS8: begin
        if (raw[2:0] != 3'd0) res.status = ST_MISALIGN;
        else if (off < 0 || off >= 'h8000) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(req.reg_n) << 5) | (32'(raw[14:3]) << 10);
      end
      K_MW2, K_MW4: begin
        if (kind == K_MW2 && req.half_sel > 2'd1) res.status = ST_RANGE;
        else res.word |= 32'(req.reg_d) | (32'(req.imm_value) << 5)
                       | (32'(req.half_sel) << 21);
      end
      default: res.status = ST_BAD_FORM;
    endcase
    if (res.status != ST_OK) res.word = '0;
    return res;
  endfunction

  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t random_request(input logic [5:0] mode);
    req_t req;
    int   ofs;
    req.mode = mode;
    req.reg_d = 5'($urandom_range(0, 31));
    req.reg_n = 5'($urandom_range(0, 31));
    req.reg_m = 5'($urandom_range(0, 31));
    req.reg_a = 5'($urandom_range(0, 31));
    req.imm_value = $urandom_range(0, 1) ? 16'($urandom_range(0, 'hFFF))
                                         : 16'($urandom_range(0, 'hFFFF));
    req.rot_or_shift = ($urandom_range(0, 2) != 0) ? 6'($urandom_range(0, 31))
                                                   : 6'($urandom_range(0, 63));
    req.mask_width = 6'($urandom_range(0, 63));
    req.half_sel = ($urandom_range(0, 3) != 0) ? 2'($urandom_range(0, 1))
                                               : 2'($urandom_range(2, 3));
    req.cond = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1:    ofs = $urandom;
      2:       ofs = int'($urandom_range(0, 2048)) - 1024;
      3, 4, 5: ofs = (int'($urandom_range(0, 1200)) - 600) & ~7;
      6, 7, 8: ofs = int'($urandom_range(0, 'h8400)) & ~3;
      default: ofs = (int'($urandom_range(0, 'h200080)) - 'h100040) & ~3;
    endcase
    req.byte_offset = ofs[27:0];
    return req;
  endfunction

  function automatic logic [5:0] random_mode();
    if ($urandom_range(0, 99) < 92) return 6'($urandom_range(0, NumForms - 1));
    return 6'($urandom_range(NumForms, 63));
  endfunction

  // called just after a rising edge; returns just after the accepting edge, or after the idle gap that follows it
  task automatic send_request(input req_t req);
    int gap;
    in_tdata <= {req.byte_offset, req.cond, req.half_sel, req.mask_width, req.rot_or_shift,
                 req.imm_value, req.reg_a, req.reg_m, req.reg_n, req.reg_d, req.mode};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_encodings.push_back(encode_request(req));
    gap = sender_idle ? idle_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_encodings.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    req_t req;
    sender_idle = 0;
    receiver_idle = 0;
    req = random_request(F_ADD_WR);
    {req.reg_d, req.reg_n, req.reg_m} = '1;
    send_request(req);
    req = random_request(F_MSUB_W);
    {req.reg_d, req.reg_n, req.reg_m, req.reg_a} = '0;
    send_request(req);
    req = random_request(F_ADD_XI);
    req.imm_value = 16'h0FFF; req.half_sel = 2'd1;
    send_request(req);
    // add/sub immediate too wide, then reserved shift
    req = random_request(F_SUB_WI);
    req.imm_value = 16'h1000; req.half_sel = 2'd0;
    send_request(req);
    req = random_request(F_CMP_WI);
    req.imm_value = 16'h0001; req.half_sel = 2'd2;
    send_request(req);
    // logical immediate, reserved and valid patterns, then immediate shifts
    req = random_request(F_AND_WI);
    req.mask_width = 6'd63;
    send_request(req);
    req = random_request(F_AND_WI);
    req.mask_width = 6'd61;
    send_request(req);
    req = random_request(F_AND_WI);
    req.mask_width = 6'd7; req.rot_or_shift = 6'd63;
    send_request(req);
    req = random_request(F_ASR_WI);
    req.rot_or_shift = 6'd32;
    send_request(req);
    req = random_request(F_LSL_WI);
    req.rot_or_shift = 6'd0;
    send_request(req);
    req = random_request(F_LSL_XI);
    req.rot_or_shift = 6'd63;
    send_request(req);
    // branch extremes and misalignment, then conditional set
    req = random_request(F_B);
    req.byte_offset = 28'h8000000;
    send_request(req);
    req = random_request(F_BL);
    req.byte_offset = 28'h7FFFFFC;
    send_request(req);
    req = random_request(F_B);
    req.byte_offset = 28'd2;
    send_request(req);
    req = random_request(F_BCOND);
    req.byte_offset = 28'hFF00000; req.cond = 4'd15;
    send_request(req);
    req = random_request(F_BCOND);
    req.byte_offset = 28'h0100000;
    send_request(req);
    req = random_request(F_BCOND);
    req.byte_offset = 28'h00FFFFC;
    send_request(req);
    req = random_request(F_CSET_W);
    req.cond = 4'd14;
    send_request(req);
    req = random_request(F_CSET_W);
    req.cond = 4'd0;
    send_request(req);
    // load/store ranges, then move-wide and invalid modes
    req = random_request(F_LDR_W);
    req.byte_offset = 28'hFFFFFFC;
    send_request(req);
    req = random_request(F_LDR_W);
    req.byte_offset = 28'h0003FFC;
    send_request(req);
    req = random_request(F_STR_X);
    req.byte_offset = 28'h0008000;
    send_request(req);
    req = random_request(F_LDR_X);
    req.byte_offset = 28'd4;
    send_request(req);
    req = random_request(F_LDP_XPOST);
    req.byte_offset = 28'hFFFFE00;
    send_request(req);
    req = random_request(F_STP_XPRE);
    req.byte_offset = 28'd512;
    send_request(req);
    req = random_request(F_MOVZ_W);
    req.half_sel = 2'd2;
    send_request(req);
    req = random_request(F_MOVK_X);
    req.half_sel = 2'd3; req.imm_value = 16'hFFFF;
    send_request(req);
    req = random_request(MODE_TOP);
    send_request(req);
    req = random_request(6'(NumForms));
    send_request(req);
  endtask

  task automatic test_random_stream(input int count);
    int phase;
    for (int i = 0; i < count; i++) begin
      phase = (i / 100) % 4;
      sender_idle = (phase == 0 || phase == 1);
      receiver_idle = (phase == 0 || phase == 2);
      send_request(random_request(random_mode()));
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_hold();
    sender_idle = 0;
    receiver_idle = 1;
    hold_request = 300;
    for (int i = 0; i < 60; i++) send_request(random_request(random_mode()));
  endtask

  task automatic test_drain_pause();
    sender_idle = 1;
    receiver_idle = 1;
    for (int i = 0; i < 30; i++) send_request(random_request(random_mode()));
    wait_for_drain();
    @(posedge clk);
    for (int i = 0; i < 30; i++) send_request(random_request(random_mode()));
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (receiver_idle) begin
        stall_left = idle_length();
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch in %s at %0t: expected %h, got %h", field, $realtime, exp_val,
               act_val);
  endtask

  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_encodings.size() == 0) begin
        report_mismatch("unexpected item word", 32'h0, out_tdata[31:0]);
      end else begin
        exp_res = pending_encodings.pop_front();
        if (out_tdata[31:0] !== exp_res.word)
          report_mismatch("word", exp_res.word, out_tdata[31:0]);
        if (out_tdata[33:32] !== exp_res.status)
          report_mismatch("status", 32'(exp_res.status), 32'(out_tdata[33:32]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_stream(880);
    test_output_hold();
    test_drain_pause();
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_encodings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/a64enc_pkg.sv
rtl/a64enc_encode.sv
rtl/arm64_instruction_encoder.sv
sim/tb_arm64_instruction_encoder.sv
